>>> rtl/decimal_seven_segment_command_stream_macros.svh
// Assertion macros used by the decimal seven-segment command stream top level.
`ifndef DECIMAL_SEVEN_SEGMENT_COMMAND_STREAM_MACROS_SVH
`define DECIMAL_SEVEN_SEGMENT_COMMAND_STREAM_MACROS_SVH

// Condition a implies condition b in the same cycle.
`define DSSC_ASSERT_IMPLIES(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("dssc assertion failed");

// Condition a implies condition b in the following cycle.
`define DSSC_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("dssc assertion failed");

`endif

>>> rtl/dssc_pkg.sv
// Package with the types, constants and segment table of the seven-segment stream.
`timescale 1ns / 1ps

package dssc_pkg;

    localparam int unsigned VALUE_W  = 15;
    localparam int unsigned BIN_W    = 14;
    localparam int unsigned DIGITS   = 4;
    localparam int unsigned STEPS    = BIN_W / 2;
    localparam int unsigned BYTES    = 2 * DIGITS;

    localparam logic [VALUE_W-1:0] VALUE_LIMIT = 15'd10000;
    localparam logic [7:0]         CMD_BASE    = 8'h7A;

    // Segment patterns for the digits 0 to 9.
    localparam logic [7:0] SEG_TABLE [10] = '{
        8'd63, 8'd6, 8'd91, 8'd79, 8'd102, 8'd109, 8'd125, 8'd7, 8'd127, 8'd111
    };

    // Control for one digit cell of the conversion chain.
    typedef struct packed {
        logic clear;
        logic shift;
    } cell_ctl_t;

    // Maps a BCD digit to its segment pattern; codes above nine show blank.
    function automatic logic [7:0] seg_pattern(input logic [3:0] digit);
        logic [7:0] pattern;
        pattern = 8'd0;
        if (digit < 4'd10)
        begin
            pattern = SEG_TABLE[digit];
        end
        return pattern;
    endfunction

endpackage

>>> rtl/dssc_digit_cell.sv
// One BCD digit cell of the shift-and-add-three conversion chain, two bits per cycle.
`timescale 1ns / 1ps

module dssc_digit_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  dssc_pkg::cell_ctl_t ctl,
    input  logic              bit_hi,
    input  logic              bit_lo,
    output logic              carry_hi,
    output logic              carry_lo,
    output logic [3:0]        digit
);
    import dssc_pkg::*;

    logic [3:0] digit_reg;
    logic [3:0] digit_next;
    logic [3:0] adj0;
    logic [3:0] step1;
    logic [3:0] adj1;

    // Two dependent dabble steps: add three where the digit is five or more, then shift.
    always_comb
    begin
        adj0       = (digit_reg >= 4'd5) ? digit_reg + 4'd3 : digit_reg;
        carry_hi   = adj0[3];
        step1      = {adj0[2:0], bit_hi};
        adj1       = (step1 >= 4'd5) ? step1 + 4'd3 : step1;
        carry_lo   = adj1[3];
        digit_next = {adj1[2:0], bit_lo};
    end

    // The digit register is cleared when a new number enters the chain.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_reg <= 4'd0;
        end
        else if (ctl.clear)
        begin
            digit_reg <= 4'd0;
        end
        else if (ctl.shift)
        begin
            digit_reg <= digit_next;
        end
    end

    assign digit = digit_reg;

endmodule

>>> rtl/dssc_serialiser.sv
// Output stage that turns four digits into the eight-byte command run.
`timescale 1ns / 1ps

module dssc_serialiser (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  logic [3:0] digit3,
    input  logic [3:0] digit2,
    input  logic [3:0] digit1,
    input  logic [3:0] digit0,
    output logic       can_load,
    output logic [7:0] tx_byte,
    output logic       last,
    output logic       out_valid,
    input  logic       out_ready
);
    import dssc_pkg::*;

    logic       busy_reg;
    logic       busy_next;
    logic [2:0] idx_reg;
    logic [2:0] idx_next;
    logic [7:0] pattern_reg [DIGITS];
    logic       out_transfer;
    logic       run_end;

    assign out_transfer = busy_reg && out_ready;
    assign run_end      = out_transfer && (idx_reg == 3'(BYTES - 1));
    assign can_load     = !busy_reg || run_end;

    // Byte index steps on every transfer; a load restarts the run.
    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (load)
        begin
            busy_next = 1'b1;
            idx_next  = 3'd0;
        end
        else if (run_end)
        begin
            busy_next = 1'b0;
            idx_next  = 3'd0;
        end
        else if (out_transfer)
        begin
            idx_next = idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= 3'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    // Segment patterns are looked up once, when the digits are handed over.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pattern_reg[0] <= seg_pattern(digit3);
            pattern_reg[1] <= seg_pattern(digit2);
            pattern_reg[2] <= seg_pattern(digit1);
            pattern_reg[3] <= seg_pattern(digit0);
        end
    end

    // Even bytes are position commands, odd bytes the position's pattern.
    always_comb
    begin
        if (idx_reg[0])
        begin
            tx_byte = pattern_reg[idx_reg[2:1]];
        end
        else
        begin
            tx_byte = CMD_BASE + {6'd0, idx_reg[2:1]} + 8'd1;
        end
    end

    assign last      = (idx_reg == 3'(BYTES - 1));
    assign out_valid = busy_reg;

endmodule

>>> rtl/decimal_seven_segment_command_stream.sv
// Top level of the decimal to seven-segment command stream.
//
// Input channel: value with in_valid / in_ready; a transfer takes one number.
// Output channel: tx_byte and last with out_valid / out_ready; each number
// from 0 to 9999 yields eight transfers: 0x7B, thousands pattern, 0x7C,
// hundreds pattern, 0x7D, tens pattern, 0x7E, units pattern (last set).
// Numbers of 10000 or more are taken and dropped without output.
// A chain of four BCD digit cells converts the number two bits per cycle;
// the result then waits in the done state until it is handed over to the
// output stage. The eight-byte output run sets the sustained rate while
// out_ready stays high. A new number is converted while the previous run
// is still being sent.
// Reset clears the conversion and output control; nothing is pending after it.
// When the receiver stalls, the current byte holds, the finished conversion
// waits for the output stage, and in_ready drops until it can be handed over.
`timescale 1ns / 1ps
`include "decimal_seven_segment_command_stream_macros.svh"

module decimal_seven_segment_command_stream (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [14:0] value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  tx_byte,
    output logic        last
);
    import dssc_pkg::*;

    logic             conv_busy_reg;
    logic             conv_busy_next;
    logic             conv_done_reg;
    logic             conv_done_next;
    logic [2:0]       cnt_reg;
    logic [2:0]       cnt_next;
    logic [BIN_W-1:0] bits_reg;
    logic             in_transfer;
    logic             value_big;
    logic             start;
    logic             handoff;
    logic             ser_can_load;
    cell_ctl_t        cell_ctl;
    logic [DIGITS:0]  chain_hi;
    logic [DIGITS:0]  chain_lo;
    logic [3:0]       digit [DIGITS];

    // Handshake: the chain takes a number once its last result has moved on.
    assign handoff     = conv_done_reg && ser_can_load;
    assign in_ready    = !conv_busy_reg && (!conv_done_reg || handoff);
    assign in_transfer = in_valid && in_ready;
    assign value_big   = (value >= VALUE_LIMIT);
    assign start       = in_transfer && !value_big;

    assign cell_ctl.clear = start;
    assign cell_ctl.shift = conv_busy_reg;

    // Conversion sequencing: seven double steps, then wait for the output stage.
    always_comb
    begin
        conv_busy_next = conv_busy_reg;
        conv_done_next = conv_done_reg;
        cnt_next       = cnt_reg;
        if (handoff)
        begin
            conv_done_next = 1'b0;
        end
        if (start)
        begin
            conv_busy_next = 1'b1;
            cnt_next       = 3'd0;
        end
        else if (conv_busy_reg)
        begin
            if (cnt_reg == 3'(STEPS - 1))
            begin
                conv_busy_next = 1'b0;
                conv_done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            conv_busy_reg <= 1'b0;
            conv_done_reg <= 1'b0;
            cnt_reg       <= 3'd0;
        end
        else
        begin
            conv_busy_reg <= conv_busy_next;
            conv_done_reg <= conv_done_next;
            cnt_reg       <= cnt_next;
        end
    end

    // Binary bits leave most significant first, two per cycle.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            bits_reg <= value[BIN_W-1:0];
        end
        else if (conv_busy_reg)
        begin
            bits_reg <= {bits_reg[BIN_W-3:0], 2'b00};
        end
    end

    assign chain_hi[0] = bits_reg[BIN_W-1];
    assign chain_lo[0] = bits_reg[BIN_W-2];

    // Row of digit cells, units first; carries pass to the next higher digit.
    for (genvar i = 0; i < DIGITS; i++)
    begin : g_cell
        dssc_digit_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (cell_ctl),
            .bit_hi   (chain_hi[i]),
            .bit_lo   (chain_lo[i]),
            .carry_hi (chain_hi[i+1]),
            .carry_lo (chain_lo[i+1]),
            .digit    (digit[i])
        );
    end

    dssc_serialiser u_serialiser (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (handoff),
        .digit3    (digit[3]),
        .digit2    (digit[2]),
        .digit1    (digit[1]),
        .digit0    (digit[0]),
        .can_load  (ser_can_load),
        .tx_byte   (tx_byte),
        .last      (last),
        .out_valid (out_valid),
        .out_ready (out_ready)
    );

    // A number below 10000 never carries out of the thousands cell.
    `DSSC_ASSERT_IMPLIES(a_no_overflow, clk, rst_n, conv_busy_reg,
        !chain_hi[DIGITS] && !chain_lo[DIGITS])
    `DSSC_ASSERT_IMPLIES(a_busy_done_excl, clk, rst_n, conv_busy_reg, !conv_done_reg)
    `DSSC_ASSERT_IMPLIES(a_cnt_range, clk, rst_n, conv_busy_reg, cnt_reg < 3'(STEPS))
    `DSSC_ASSERT_NEXT(a_start_busy, clk, rst_n, start, conv_busy_reg && cnt_reg == 3'd0)
    `DSSC_ASSERT_NEXT(a_handoff_out, clk, rst_n, handoff, out_valid && tx_byte == CMD_BASE + 8'd1)

endmodule
